### rtl/srp_pkg.sv
// Shared constants and the scale clamp for the smootherstep ramp profile block.
package srp_pkg;

	localparam int SRP_FRAC_BITS = 16;
	localparam int TIME_W        = 32;
	localparam int SCALE_W       = 16;
	localparam int SCALE_IN_W    = 17;
	localparam int DRIVE_W       = 16;
	localparam int Q15_SHIFT     = 15;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 16'h8000;

	// Clamps a signed Q15 value into the range 0 .. 1.0.
	function automatic logic [SCALE_W-1:0] clamp_q15(input logic signed [SCALE_IN_W-1:0] v);
		logic [SCALE_W-1:0] r;
		if (v[SCALE_IN_W-1]) begin
			r = '0;
		end else if (v > $signed({1'b0, SCALE_ONE})) begin
			r = SCALE_ONE;
		end else begin
			r = v[SCALE_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/srp_div.sv
// Restoring divider that produces one quotient bit per cycle.
module srp_div import srp_pkg::*; #(
	parameter int NW = TIME_W,
	parameter int QW = SRP_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] den_q;
	logic [QW-1:0] quo_q;

	logic [NW:0] rem2;
	logic        ge;
	logic [NW:0] rem_next;

	// The numerator is always below the divisor, so twice the remainder fits NW+1 bits.
	assign rem2     = {rem_q, 1'b0};
	assign ge       = rem2 >= {1'b0, den_q};
	assign rem_next = ge ? (rem2 - {1'b0, den_q}) : rem2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next[NW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/srp_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module srp_mul import srp_pkg::*; #(
	parameter int AW = SCALE_W,
	parameter int BW = SCALE_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] p
);

	localparam int PW = AW + BW;

	logic          busy_q;
	logic          done_q;
	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [PW-1:0] p_q;

	// The unit stops as soon as no set multiplier bit is left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= PW'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= {a_q[PW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

### rtl/smootherstep_ramp_profile.sv
// Top level of the smootherstep ramp profile: sequencer, ramp state and output register.
//
// Usage: one input word per command on the in_valid / in_ready channel. A start word
// (command = 1) latches clamped start and end scales, the start time and the ramp length;
// a sample word (command = 0) evaluates the quintic smootherstep curve at now_ms while a
// ramp runs. Every input word produces exactly one output word on out_valid / out_ready
// carrying the current Q15 scale, the ramp-active flag and drive_value scaled by that
// scale. One word is worked on at a time; in_ready rises on the same edge that raises
// out_valid, so the next word can be taken while that result waits. Start words and
// idle samples take the drive multiply only; a sample past the end of the ramp adds the
// elapsed-time check first. A sample inside the ramp runs the serial divider for
// FRAC_BITS quotient bits and then five passes of the shared serial multiplier, each
// retiring one multiplier bit per cycle and stopping after its highest set bit. These
// shared serial units set how long a sample inside the ramp takes.
// Reset (arst_n low) clears the ramp state to zero and idle and drops out_valid.
// The output register parts the two channels: a new word is accepted while the previous
// result still waits, and a finished result stalls in the sequencer only until the
// receiver takes the waiting word. Held results keep their payload stable.
module smootherstep_ramp_profile import srp_pkg::*; #(
	parameter int FRAC_BITS = SRP_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [TIME_W-1:0]            now_ms,
	input  logic signed [SCALE_IN_W-1:0] start_scale_in,
	input  logic signed [SCALE_IN_W-1:0] end_scale_in,
	input  logic [TIME_W-1:0]            ramp_length_ms,
	input  logic signed [DRIVE_W-1:0]    drive_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [SCALE_W-1:0]           scale_out,
	output logic                         ramp_active,
	output logic signed [DRIVE_W-1:0]    scaled_drive
);

	localparam int F  = FRAC_BITS;
	localparam int IW = F + 4;
	localparam int SW = F + 1;
	localparam int AW = (IW > SCALE_W) ? IW : SCALE_W;
	localparam int BW = (SW > SCALE_W) ? SW : SCALE_W;
	localparam int PW = AW + BW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_DIV,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_DRV,
		S_DRVW,
		S_OUT
	} state_t;

	state_t state_q;

	// Ramp state.
	logic [SCALE_W-1:0] from_q;
	logic [SCALE_W-1:0] to_q;
	logic [SCALE_W-1:0] scale_q;
	logic [TIME_W-1:0]  begin_q;
	logic [TIME_W-1:0]  dur_q;
	logic               running_q;

	// Per-word working registers.
	logic [TIME_W-1:0]  elapsed_q;
	logic [DRIVE_W-1:0] drive_q;
	logic [F-1:0]       u_q;
	logic [2*F-1:0]     uu_q;
	logic [IW-1:0]      inner_q;
	logic [DRIVE_W-1:0] drv_res_q;

	logic          mul_start_q;
	logic [AW-1:0] mul_a_q;
	logic [BW-1:0] mul_b_q;
	logic          mul_done;
	logic [PW-1:0] mul_p;

	logic         div_start_q;
	logic         div_done;
	logic [F-1:0] div_quo;

	srp_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start_q),
		.a     (mul_a_q),
		.b     (mul_b_q),
		.done  (mul_done),
		.p     (mul_p)
	);

	srp_div #(
		.NW(TIME_W),
		.QW(F)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (elapsed_q),
		.den   (dur_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Clamped scales of the incoming word, used only by a start word.
	logic [SCALE_W-1:0] from_in;
	logic [SCALE_W-1:0] to_in;
	assign from_in = clamp_q15(start_scale_in);
	assign to_in   = clamp_q15(end_scale_in);

	// The upper half of u*u (first pass) and of u^2*u (second pass).
	logic [F-1:0] prod_hi;
	assign prod_hi = mul_p[2*F-1:F];

	// Inner polynomial 6u^2 - 15u + 10, taken modulo 2^IW; the true value is always
	// positive and below 2^IW, so the wrap in the intermediate sum is harmless.
	// 15u is formed as 16u - u.
	logic [2*F+2:0] six_uu;
	logic [IW-1:0]  inner_c;
	assign six_uu  = (2*F+3)'({uu_q, 2'b00}) + (2*F+3)'({uu_q, 1'b0});
	assign inner_c = IW'(six_uu >> F) + (IW'(10) << F)
		- ((IW'(u_q) << 4) - IW'(u_q));

	// Curve value s from the third pass, saturated to 1.0.
	logic [IW-1:0] s_raw;
	logic [IW-1:0] one_iw;
	logic [SW-1:0] s_sat;
	assign s_raw  = mul_p[2*F+3:F];
	assign one_iw = IW'(1) << F;
	assign s_sat  = (s_raw > one_iw) ? SW'(one_iw) : s_raw[SW-1:0];

	// Interpolation between the scales, by magnitude and direction.
	logic               to_ge;
	logic [SCALE_W-1:0] mag;
	logic [SCALE_W-1:0] mag_s;
	logic [SCALE_W-1:0] new_scale;
	assign to_ge     = to_q >= from_q;
	assign mag       = to_ge ? (to_q - from_q) : (from_q - to_q);
	assign mag_s     = mul_p[F+SCALE_W-1:F];
	assign new_scale = to_ge ? (from_q + mag_s) : (from_q - mag_s);

	// Drive scaling on magnitudes, so the quotient truncates toward zero.
	logic               drv_neg;
	logic [DRIVE_W-1:0] drv_mag;
	logic [DRIVE_W-1:0] q_mag;
	logic [DRIVE_W-1:0] drv_res;
	assign drv_neg = drive_q[DRIVE_W-1];
	assign drv_mag = drv_neg ? (~drive_q + DRIVE_W'(1)) : drive_q;
	assign q_mag   = mul_p[Q15_SHIFT+DRIVE_W-1:Q15_SHIFT];
	assign drv_res = drv_neg ? (~q_mag + DRIVE_W'(1)) : q_mag;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			from_q       <= '0;
			to_q         <= '0;
			scale_q      <= '0;
			begin_q      <= '0;
			dur_q        <= '0;
			running_q    <= 1'b0;
			elapsed_q    <= '0;
			drive_q      <= '0;
			u_q          <= '0;
			uu_q         <= '0;
			inner_q      <= '0;
			drv_res_q    <= '0;
			mul_start_q  <= 1'b0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			div_start_q  <= 1'b0;
			out_valid    <= 1'b0;
			scale_out    <= '0;
			ramp_active  <= 1'b0;
			scaled_drive <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						drive_q <= drive_value;
						if (command) begin
							from_q    <= from_in;
							to_q      <= to_in;
							begin_q   <= now_ms;
							dur_q     <= ramp_length_ms;
							running_q <= (ramp_length_ms != '0);
							// A zero-length ramp jumps straight to the end scale.
							scale_q   <= (ramp_length_ms != '0) ? from_in : to_in;
							state_q   <= S_DRV;
						end else if (running_q) begin
							elapsed_q <= now_ms - begin_q;
							state_q   <= S_CHK;
						end else begin
							// A sample while idle holds the scale.
							state_q <= S_DRV;
						end
					end
				end
				S_CHK: begin
					if (elapsed_q >= dur_q) begin
						scale_q   <= to_q;
						running_q <= 1'b0;
						state_q   <= S_DRV;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						u_q         <= div_quo;
						mul_a_q     <= AW'(div_quo);
						mul_b_q     <= BW'(div_quo);
						mul_start_q <= 1'b1;
						state_q     <= S_M1;
					end
				end
				S_M1: begin
					if (mul_done) begin
						uu_q        <= mul_p[2*F-1:0];
						mul_a_q     <= AW'(prod_hi);
						mul_b_q     <= BW'(u_q);
						mul_start_q <= 1'b1;
						state_q     <= S_M2;
					end
				end
				S_M2: begin
					// The inner polynomial settles while u^3 is being formed.
					inner_q <= inner_c;
					if (mul_done) begin
						mul_a_q     <= AW'(inner_q);
						mul_b_q     <= BW'(prod_hi);
						mul_start_q <= 1'b1;
						state_q     <= S_M3;
					end
				end
				S_M3: begin
					if (mul_done) begin
						mul_a_q     <= AW'(mag);
						mul_b_q     <= BW'(s_sat);
						mul_start_q <= 1'b1;
						state_q     <= S_M4;
					end
				end
				S_M4: begin
					if (mul_done) begin
						scale_q <= new_scale;
						state_q <= S_DRV;
					end
				end
				S_DRV: begin
					mul_a_q     <= AW'(drv_mag);
					mul_b_q     <= BW'(scale_q);
					mul_start_q <= 1'b1;
					state_q     <= S_DRVW;
				end
				S_DRVW: begin
					if (mul_done) begin
						drv_res_q <= drv_res;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						scale_out    <= scale_q;
						ramp_active  <= running_q;
						scaled_drive <= drv_res_q;
						out_valid    <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/srp_checker.sv
// Port-level checker for the smootherstep ramp profile and its bind to the top level.
module srp_checker import srp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [SCALE_W-1:0]        scale_out,
	input logic                      ramp_active,
	input logic signed [DRIVE_W-1:0] scaled_drive
);

	// A waiting result word holds its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scale_out)
			&& $stable(scaled_drive) && $stable(ramp_active))
		else $error("output word changed while stalled");

	// The scale never leaves the range 0 .. 1.0.
	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> scale_out <= SCALE_ONE)
		else $error("scale above 1.0");

	// The block works on one word at a time, so it is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// A zero scale gives a zero drive.
	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (scale_out == '0) |-> scaled_drive == '0)
		else $error("nonzero drive at zero scale");

endmodule

bind smootherstep_ramp_profile srp_checker u_srp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.scale_out   (scale_out),
	.ramp_active (ramp_active),
	.scaled_drive(scaled_drive)
);
